[rtl/sjcl_pkg.sv]
// shared types, codes and elaboration-time math for the jog and lift sequencer
`default_nettype none

package sjcl_pkg;

	localparam int unsigned PROFILE_STEPS_DEF = 150;

	localparam int unsigned POS_W   = 12;
	localparam int unsigned ARM_W   = 21;
	localparam int unsigned MSG_W   = 8;
	localparam int unsigned SEL_W   = 2;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 21;
	localparam int unsigned WEIGHT_W = 17;

	localparam int unsigned IN_DATA_W  = 16;
	localparam int unsigned OUT_DATA_W = 48;
	localparam int unsigned OUT_USER_W = 2;

	localparam logic signed [ARM_W+1:0] ARM_MAX = 23'sd1048575;
	localparam logic signed [ARM_W+1:0] ARM_MIN = -23'sd1048575;

	typedef enum logic [SEL_W-1:0] {
		MODE_TICK = 2'd0,
		MODE_JOG  = 2'd1,
		MODE_LIFT = 2'd2,
		MODE_TELE = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_JOG_STEP    = 3'd0,
		CFG_GRIP_CLOSE  = 3'd1,
		CFG_GRIP_OPEN   = 3'd2,
		CFG_LIFT_DOWN   = 3'd3,
		CFG_LIFT_UP     = 3'd4,
		CFG_ARM_START   = 3'd5,
		CFG_LIFT_START  = 3'd6
	} cfg_idx_t;

	localparam logic [SEL_W-1:0] JOG_UP     = 2'd1;
	localparam logic [SEL_W-1:0] JOG_DOWN   = 2'd2;
	localparam logic [SEL_W-1:0] GRIP_CLOSE = 2'd1;
	localparam logic [SEL_W-1:0] GRIP_OPEN  = 2'd2;
	localparam logic [SEL_W-1:0] BTN_DOWN   = 2'd1;
	localparam logic [SEL_W-1:0] BTN_UP     = 2'd2;

	localparam logic signed [MSG_W-1:0] TELE_SEND       = 8'sd3;
	localparam logic signed [MSG_W-1:0] TELE_HALT       = 8'sd4;
	localparam logic signed [MSG_W-1:0] LIFT_CMD_DOWN   = 8'sd1;
	localparam logic signed [MSG_W-1:0] LIFT_CMD_UP     = 8'sd0;

	localparam longint unsigned Q30_ONE = 64'd1073741824;
	localparam longint unsigned PI_Q30  = 64'd3373259426;

	typedef struct packed {
		logic                    arm_write;
		logic signed [ARM_W-1:0] arm_goal;
		logic                    gripper_write;
		logic [POS_W-1:0]        gripper_goal;
		logic [POS_W-1:0]        lift_goal;
	} result_t;

	// taylor cosine in q30, angle in [0, pi/2]; elaboration only
	function automatic longint cos_q30(longint unsigned a);
		longint unsigned x2;
		longint unsigned t;
		x2 = (a * a) >> 30;
		t = Q30_ONE - x2 / 90;
		t = Q30_ONE - ((x2 * t) >> 30) / 56;
		t = Q30_ONE - ((x2 * t) >> 30) / 30;
		t = Q30_ONE - ((x2 * t) >> 30) / 12;
		return longint'(Q30_ONE) - longint'(((x2 * t) >> 30) / 2);
	endfunction

endpackage

`default_nettype wire

[rtl/servo_jog_and_cosine_lift_sequencer.sv]
// top level of the servo jog and raised-cosine lift sequencer
//
//  channel   direction  handshake               payload
//  s_axis    in         s_axis_tvalid/tready    tuser: mode; tdata: event fields
//  m_axis    out        m_axis_tvalid/tready    tuser: write flags; tdata: goals
//  cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
//  one event per cycle while s_axis_tready is high; tick results leave m_axis registered
//  the weight table lookup and one 17x13 multiply form the combinational result path
//  s_axis_tready drops only when both the result register and the skid entry are full
//  cfg_ready is always high; arst_n resets all but the output data registers at once
`default_nettype none

module servo_jog_and_cosine_lift_sequencer #(
	parameter int unsigned PROFILE_STEPS = sjcl_pkg::PROFILE_STEPS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// jog_dir[1:0], grip_cmd[3:2], lift_button[5:4], message_value[13:6], zero[15:14]
	input  wire logic [sjcl_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// mode[1:0]
	input  wire logic [sjcl_pkg::SEL_W-1:0]       s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// arm_goal[20:0], gripper_goal[32:21], lift_goal[44:33], zero[47:45]
	output logic [sjcl_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
	// arm_write[0], gripper_write[1]
	output logic [sjcl_pkg::OUT_USER_W-1:0]       m_axis_tuser,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [sjcl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sjcl_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import sjcl_pkg::*;

	localparam int unsigned STEP_W = $clog2(PROFILE_STEPS + 1);

	logic    in_fire;
	logic    cfg_fire;
	logic    res_push;
	result_t res;
	result_t out_res;

	assign cfg_ready = 1'b1;
	assign cfg_fire = cfg_valid && cfg_ready;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	sjcl_core #(
		.PROFILE_STEPS(PROFILE_STEPS),
		.STEP_W(STEP_W)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_fire(cfg_fire),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_fire(in_fire),
		.mode(s_axis_tuser),
		.jog_dir(s_axis_tdata[1:0]),
		.grip_cmd(s_axis_tdata[3:2]),
		.lift_button(s_axis_tdata[5:4]),
		.message_value($signed(s_axis_tdata[13:6])),
		.res_push(res_push),
		.res(res)
	);

	sjcl_out_buf u_out_buf (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.din(res),
		.in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.dout(out_res)
	);

	assign m_axis_tdata = {3'b0, out_res.lift_goal, out_res.gripper_goal, out_res.arm_goal};
	assign m_axis_tuser = {out_res.gripper_write, out_res.arm_write};

endmodule

`default_nettype wire

[rtl/sjcl_lift_profile.sv]
// raised-cosine weight table and one profile step of the lift position
`default_nettype none

module sjcl_lift_profile #(
	parameter int unsigned PROFILE_STEPS = sjcl_pkg::PROFILE_STEPS_DEF,
	parameter int unsigned STEP_W = $clog2(PROFILE_STEPS + 1)
) (
	input  wire logic [STEP_W-1:0]          step,
	input  wire logic [sjcl_pkg::POS_W-1:0] origin,
	input  wire logic [sjcl_pkg::POS_W-1:0] target,
	output logic      [sjcl_pkg::POS_W-1:0] position
);
	import sjcl_pkg::*;

	typedef logic [WEIGHT_W-1:0] wtab_t [PROFILE_STEPS];

	function automatic logic [WEIGHT_W-1:0] weight(int unsigned k);
		longint unsigned m;
		longint unsigned a;
		longint c;
		longint num;
		longint w;
		bit low_half;
		low_half = (2 * k <= PROFILE_STEPS);
		m = low_half ? longint'(k) : longint'(PROFILE_STEPS - k);
		a = (PI_Q30 * m) / PROFILE_STEPS;
		c = cos_q30(a);
		num = low_half ? longint'(Q30_ONE) - c : longint'(Q30_ONE) + c;
		if (num < 0) begin
			num = 0;
		end
		w = (num + 16384) >>> 15;
		if (w > 65536) begin
			w = 65536;
		end
		return w[WEIGHT_W-1:0];
	endfunction

	function automatic wtab_t build_table();
		wtab_t tab;
		for (int unsigned k = 0; k < PROFILE_STEPS; k++) begin
			tab[k] = weight(k);
		end
		return tab;
	endfunction

	localparam wtab_t WTAB = build_table();

	logic [STEP_W-1:0]          idx;
	logic [WEIGHT_W-1:0]        w;
	logic signed [POS_W:0]      d;
	logic signed [31:0]         prod;
	logic signed [31:0]         acc;

	always_comb begin
		idx = (step < STEP_W'(PROFILE_STEPS)) ? step : '0;
		w = WTAB[idx];
		d = $signed({1'b0, target}) - $signed({1'b0, origin});
		prod = 32'($signed({1'b0, w}) * d);
		acc = $signed({4'b0, origin, 16'b0}) + prod;
		position = acc[31] ? '0 : acc[POS_W+15:16];
	end

endmodule

`default_nettype wire

[rtl/sjcl_core.sv]
// configuration registers, event state and tick result formation
`default_nettype none

module sjcl_core #(
	parameter int unsigned PROFILE_STEPS = sjcl_pkg::PROFILE_STEPS_DEF,
	parameter int unsigned STEP_W = $clog2(PROFILE_STEPS + 1)
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_fire,
	input  wire logic [sjcl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sjcl_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            in_fire,
	input  wire logic [sjcl_pkg::SEL_W-1:0]      mode,
	input  wire logic [sjcl_pkg::SEL_W-1:0]      jog_dir,
	input  wire logic [sjcl_pkg::SEL_W-1:0]      grip_cmd,
	input  wire logic [sjcl_pkg::SEL_W-1:0]      lift_button,
	input  wire logic signed [sjcl_pkg::MSG_W-1:0] message_value,
	output logic                                 res_push,
	output sjcl_pkg::result_t                    res
);
	import sjcl_pkg::*;

	logic [POS_W-1:0]        jog_step_q;
	logic [POS_W-1:0]        grip_close_q;
	logic [POS_W-1:0]        grip_open_q;
	logic [POS_W-1:0]        lift_down_q;
	logic [POS_W-1:0]        lift_up_q;

	logic signed [ARM_W-1:0] arm_pos_q;
	logic                    arm_pending_q;
	logic [POS_W-1:0]        grip_target_q;
	logic                    grip_pending_q;
	logic signed [MSG_W-1:0] tele_code_q;
	logic                    halt_latch_q;
	logic signed [MSG_W-1:0] lift_cmd_q;
	logic [POS_W-1:0]        lift_origin_q;
	logic [POS_W-1:0]        lift_pos_q;
	logic [POS_W-1:0]        lift_target_q;
	logic [STEP_W-1:0]       step_q;

	logic signed [ARM_W+1:0] arm_sum;
	logic signed [ARM_W-1:0] arm_next;
	logic [POS_W-1:0]        target_next;
	logic [POS_W-1:0]        pos_calc;
	logic                    at_end;
	logic                    send_arm;
	logic                    send_grip;
	logic                    btn_restart;

	sjcl_lift_profile #(
		.PROFILE_STEPS(PROFILE_STEPS),
		.STEP_W(STEP_W)
	) u_profile (
		.step(step_q),
		.origin(lift_origin_q),
		.target(target_next),
		.position(pos_calc)
	);

	always_comb begin
		if (jog_dir == JOG_UP) begin
			arm_sum = $signed({{2{arm_pos_q[ARM_W-1]}}, arm_pos_q})
				- $signed({11'b0, jog_step_q});
		end else begin
			arm_sum = $signed({{2{arm_pos_q[ARM_W-1]}}, arm_pos_q})
				+ $signed({11'b0, jog_step_q});
		end
		if (arm_sum > ARM_MAX) begin
			arm_next = ARM_MAX[ARM_W-1:0];
		end else if (arm_sum < ARM_MIN) begin
			arm_next = ARM_MIN[ARM_W-1:0];
		end else begin
			arm_next = arm_sum[ARM_W-1:0];
		end

		if (lift_cmd_q == LIFT_CMD_DOWN) begin
			target_next = lift_down_q;
		end else if (lift_cmd_q == LIFT_CMD_UP) begin
			target_next = lift_up_q;
		end else begin
			target_next = lift_target_q;
		end
		at_end = (step_q >= STEP_W'(PROFILE_STEPS));

		send_arm = (tele_code_q == TELE_SEND) && arm_pending_q;
		send_grip = (tele_code_q == TELE_SEND) && grip_pending_q;
		btn_restart = halt_latch_q && ((lift_button == BTN_DOWN) || (lift_button == BTN_UP));

		res_push = in_fire && (mode_t'(mode) == MODE_TICK);
		res.arm_write = send_arm;
		res.arm_goal = send_arm ? arm_pos_q : '0;
		res.gripper_write = send_grip;
		res.gripper_goal = send_grip ? grip_target_q : '0;
		res.lift_goal = at_end ? target_next : pos_calc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jog_step_q <= 12'd60;
			grip_close_q <= 12'd1890;
			grip_open_q <= 12'd745;
			lift_down_q <= 12'd2075;
			lift_up_q <= 12'd3230;
			arm_pos_q <= '0;
			arm_pending_q <= 1'b0;
			grip_target_q <= '0;
			grip_pending_q <= 1'b0;
			tele_code_q <= '0;
			halt_latch_q <= 1'b0;
			lift_cmd_q <= LIFT_CMD_DOWN;
			lift_origin_q <= '0;
			lift_pos_q <= '0;
			lift_target_q <= '0;
			step_q <= '0;
		end else if (cfg_fire) begin
			case (cfg_idx_t'(cfg_index))
				CFG_JOG_STEP: jog_step_q <= cfg_data[POS_W-1:0];
				CFG_GRIP_CLOSE: grip_close_q <= cfg_data[POS_W-1:0];
				CFG_GRIP_OPEN: grip_open_q <= cfg_data[POS_W-1:0];
				CFG_LIFT_DOWN: lift_down_q <= cfg_data[POS_W-1:0];
				CFG_LIFT_UP: lift_up_q <= cfg_data[POS_W-1:0];
				CFG_ARM_START: begin
					arm_pos_q <= $signed(cfg_data[ARM_W-1:0]);
				end
				CFG_LIFT_START: begin
					lift_origin_q <= cfg_data[POS_W-1:0];
					lift_pos_q <= cfg_data[POS_W-1:0];
				end
				default: ;
			endcase
		end else if (in_fire) begin
			case (mode_t'(mode))
				MODE_JOG: begin
					if ((jog_dir == JOG_UP) || (jog_dir == JOG_DOWN)) begin
						arm_pos_q <= arm_next;
						arm_pending_q <= 1'b1;
					end
					if (grip_cmd == GRIP_CLOSE) begin
						grip_target_q <= grip_close_q;
						grip_pending_q <= 1'b1;
					end else if (grip_cmd == GRIP_OPEN) begin
						grip_target_q <= grip_open_q;
						grip_pending_q <= 1'b1;
					end
					if (btn_restart) begin
						lift_cmd_q <= (lift_button == BTN_DOWN) ? LIFT_CMD_DOWN : LIFT_CMD_UP;
						lift_origin_q <= lift_pos_q;
						step_q <= '0;
					end
				end
				MODE_LIFT: begin
					if (message_value != lift_cmd_q) begin
						lift_cmd_q <= message_value;
						lift_origin_q <= lift_pos_q;
						step_q <= '0;
					end
				end
				MODE_TELE: begin
					tele_code_q <= message_value;
					if (message_value == TELE_HALT) begin
						halt_latch_q <= 1'b1;
					end
				end
				MODE_TICK: begin
					if (send_arm) begin
						arm_pending_q <= 1'b0;
					end
					if (send_grip) begin
						grip_pending_q <= 1'b0;
					end
					lift_target_q <= target_next;
					if (at_end) begin
						lift_pos_q <= target_next;
						step_q <= STEP_W'(PROFILE_STEPS);
					end else begin
						lift_pos_q <= pos_calc;
						step_q <= step_q + STEP_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	property p_step_bounded;
		@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_W'(PROFILE_STEPS);
	endproperty
	a_step_bounded: assert property (p_step_bounded)
		else $error("profile step ran past the end");

	property p_send_clears;
		@(posedge clk) disable iff (!arst_n)
		(res_push && send_arm && !cfg_fire) |=> !arm_pending_q;
	endproperty
	a_send_clears: assert property (p_send_clears)
		else $error("arm pending not cleared after send");

	property p_latch_sticky;
		@(posedge clk) disable iff (!arst_n)
		halt_latch_q |=> halt_latch_q;
	endproperty
	a_latch_sticky: assert property (p_latch_sticky)
		else $error("halt latch dropped");

endmodule

`default_nettype wire

[rtl/sjcl_out_buf.sv]
// result register with one skid entry on the output stream
`default_nettype none

module sjcl_out_buf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire sjcl_pkg::result_t din,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output sjcl_pkg::result_t      dout
);
	import sjcl_pkg::*;

	logic    out_v_q;
	logic    skid_v_q;
	result_t out_q;
	result_t skid_q;
	logic    pop;

	assign pop = out_v_q && out_ready;
	assign in_ready = !skid_v_q;
	assign out_valid = out_v_q;
	assign dout = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop && skid_v_q) begin
			out_v_q <= 1'b1;
			skid_v_q <= 1'b0;
		end else if (pop || !out_v_q) begin
			out_v_q <= push;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_v_q) begin
			out_q <= skid_q;
		end else if (pop || !out_v_q) begin
			out_q <= din;
		end else if (push) begin
			skid_q <= din;
		end
	end

	property p_skid_implies_out;
		@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q;
	endproperty
	a_skid_implies_out: assert property (p_skid_implies_out)
		else $error("skid entry held with empty output register");

	property p_push_to_skid;
		@(posedge clk) disable iff (!arst_n)
		(push && out_v_q && !pop) |=> skid_v_q;
	endproperty
	a_push_to_skid: assert property (p_push_to_skid)
		else $error("result lost while output stalled");

	property p_skid_drain;
		@(posedge clk) disable iff (!arst_n)
		(skid_v_q && pop) |=> (out_v_q && !skid_v_q);
	endproperty
	a_skid_drain: assert property (p_skid_drain)
		else $error("skid entry not moved to output");

endmodule

`default_nettype wire
